// ===== sv/tpc_pkg.sv =====
// Shared types, sizes and codes for the trie prefix counter.
`default_nettype none

package tpc_pkg;

    localparam int MAX_NODES      = 65536;
    localparam int NODE_BITS      = $clog2(MAX_NODES);
    localparam int USED_BITS      = $clog2(MAX_NODES + 1);
    localparam int ALPHABET       = 26;
    localparam int LETTER_BITS    = 5;
    localparam int LINK_DEPTH     = MAX_NODES * ALPHABET;
    localparam int LINK_ADDR_BITS = $clog2(LINK_DEPTH);
    localparam int COUNT_BITS     = 32;
    localparam int OUT_COUNT_BITS = 32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_POOL_FULL = 2'd2;

    typedef struct packed {
        logic                   action;
        logic [LETTER_BITS-1:0] letter;
        logic                   last_letter;
    } letter_req_t;

    typedef struct packed {
        logic [OUT_COUNT_BITS-1:0] prefix_count;
        logic [1:0]                status;
        logic                      done_action;
    } result_req_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]   parent;
        logic [LETTER_BITS-1:0] letter;
        logic [COUNT_BITS-1:0]  count;
    } node_entry_t;

    typedef struct packed {
        logic                      link_rd;
        logic                      link_wr;
        logic [LINK_ADDR_BITS-1:0] link_addr;
        logic [NODE_BITS-1:0]      link_wdata;
        logic                      node_rd;
        logic [NODE_BITS-1:0]      node_raddr;
        logic                      node_wr;
        logic [NODE_BITS-1:0]      node_waddr;
        node_entry_t               node_wdata;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== sv/tpc_store.sv =====
// Link memory and node memory of the trie, each with a registered read port.
`default_nettype none

module tpc_store
    import tpc_pkg::*;
(
    input  wire logic           clk,
    input  wire mem_req_t       req,
    output logic [NODE_BITS-1:0] link_rdata,
    output node_entry_t          node_rdata
);

    logic [NODE_BITS-1:0] link_mem [LINK_DEPTH];
    node_entry_t          node_mem [MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (req.link_wr)
        begin
            link_mem[req.link_addr] <= req.link_wdata;
        end
        if (req.link_rd)
        begin
            link_rdata <= link_mem[req.link_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.node_wr)
        begin
            node_mem[req.node_waddr] <= req.node_wdata;
        end
        if (req.node_rd)
        begin
            node_rdata <= node_mem[req.node_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/trie_prefix_counter.sv =====
// Top level of the trie prefix counter: letter sequencer, node pool control and result register.
// A letter passes through accept, link read, node read, and check and update; a last letter
// then loads the result register in a finish step, which waits while that register is stalled.
// A letter of a word that has already failed skips the lookup. All steps share one link port.
// Reset is asynchronous and takes effect at once: no clearing pass runs, because a stored link
// counts only if it names an allocated node whose recorded parent and letter match the lookup.
`default_nettype none

module trie_prefix_counter
    import tpc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  letter_valid,
    output logic       letter_stall,
    input  wire letter_req_t letter_req,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_req_t result_req
);

    typedef enum logic [2:0] {
        IDLE,
        RD_LINK,
        RD_NODE,
        CHECK,
        FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic [NODE_BITS-1:0]      cur_reg, cur_next;
    logic [USED_BITS-1:0]      used_reg, used_next;
    logic                      failed_reg, failed_next;
    logic                      overflow_reg, overflow_next;
    logic                      act_reg, act_next;
    logic [LETTER_BITS-1:0]    let_reg, let_next;
    logic                      last_reg, last_next;
    logic [LINK_ADDR_BITS-1:0] addr_reg, addr_next;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic                      out_valid_reg, out_valid_next;
    result_req_t               out_reg, out_next;

    mem_req_t             mem_req;
    logic [NODE_BITS-1:0] link_rdata;
    node_entry_t          node_rdata;
    logic                 hit;
    logic [COUNT_BITS-1:0] count_inc;
    logic                 accept;

    tpc_store u_store (
        .clk        (clk),
        .req        (mem_req),
        .link_rdata (link_rdata),
        .node_rdata (node_rdata)
    );

    assign letter_stall = (state_reg != IDLE);
    assign accept       = letter_valid && !letter_stall;
    assign result_valid = out_valid_reg;
    assign result_req   = out_reg;

    assign hit = (link_rdata != '0)
              && ({1'b0, link_rdata} < used_reg)
              && (node_rdata.parent == cur_reg)
              && (node_rdata.letter == let_reg);

    assign count_inc = (node_rdata.count == '1) ? node_rdata.count
                                                : node_rdata.count + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        used_next      = used_reg;
        failed_next    = failed_reg;
        overflow_next  = overflow_reg;
        act_next       = act_reg;
        let_next       = let_reg;
        last_next      = last_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        mem_req        = '0;
        mem_req.link_addr = addr_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    act_next  = letter_req.action;
                    let_next  = letter_req.letter;
                    last_next = letter_req.last_letter;
                    addr_next = LINK_ADDR_BITS'(cur_reg) * LINK_ADDR_BITS'(ALPHABET)
                              + LINK_ADDR_BITS'(letter_req.letter);
                    if (failed_reg || (letter_req.letter >= LETTER_BITS'(ALPHABET)))
                    begin
                        failed_next = 1'b1;
                        state_next  = letter_req.last_letter ? FINISH : IDLE;
                    end
                    else
                    begin
                        state_next = RD_LINK;
                    end
                end
            end
            RD_LINK:
            begin
                mem_req.link_rd = 1'b1;
                state_next      = RD_NODE;
            end
            RD_NODE:
            begin
                mem_req.node_rd    = 1'b1;
                mem_req.node_raddr = link_rdata;
                state_next         = CHECK;
            end
            CHECK:
            begin
                if (hit)
                begin
                    cur_next = link_rdata;
                    if (act_reg == ACT_INSERT)
                    begin
                        mem_req.node_wr    = 1'b1;
                        mem_req.node_waddr = link_rdata;
                        mem_req.node_wdata = '{parent: node_rdata.parent,
                                               letter: node_rdata.letter,
                                               count:  count_inc};
                        count_next = count_inc;
                    end
                    else
                    begin
                        count_next = node_rdata.count;
                    end
                end
                else if (act_reg == ACT_QUERY)
                begin
                    failed_next = 1'b1;
                end
                else if (used_reg < USED_BITS'(MAX_NODES))
                begin
                    mem_req.link_wr    = 1'b1;
                    mem_req.link_wdata = used_reg[NODE_BITS-1:0];
                    mem_req.node_wr    = 1'b1;
                    mem_req.node_waddr = used_reg[NODE_BITS-1:0];
                    mem_req.node_wdata = '{parent: cur_reg,
                                           letter: let_reg,
                                           count:  COUNT_BITS'(1)};
                    cur_next   = used_reg[NODE_BITS-1:0];
                    used_next  = used_reg + 1'b1;
                    count_next = COUNT_BITS'(1);
                end
                else
                begin
                    failed_next   = 1'b1;
                    overflow_next = 1'b1;
                end
                state_next = last_reg ? FINISH : IDLE;
            end
            FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.done_action = act_reg;
                    if (overflow_reg)
                    begin
                        out_next.status       = STATUS_POOL_FULL;
                        out_next.prefix_count = '0;
                    end
                    else if (failed_reg)
                    begin
                        out_next.status       = STATUS_NOT_FOUND;
                        out_next.prefix_count = '0;
                    end
                    else
                    begin
                        out_next.status       = STATUS_OK;
                        out_next.prefix_count = OUT_COUNT_BITS'(count_reg);
                    end
                    cur_next      = '0;
                    failed_next   = 1'b0;
                    overflow_next = 1'b0;
                    state_next    = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cur_reg       <= '0;
            used_reg      <= USED_BITS'(1);
            failed_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            used_reg      <= used_next;
            failed_reg    <= failed_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        let_reg   <= let_next;
        last_reg  <= last_next;
        addr_reg  <= addr_next;
        count_reg <= count_next;
        out_reg   <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg >= USED_BITS'(1)) && (used_reg <= USED_BITS'(MAX_NODES)))
        else $error("node pool count out of range");

    a_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_reg} < used_reg)
        else $error("current node is not an allocated node");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == FINISH))
        else $error("result loaded outside the finish step");

    a_fail_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_req.status != STATUS_OK)) |-> (result_req.prefix_count == '0))
        else $error("failed word reports a nonzero count");

    a_overflow_is_failed: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> failed_reg)
        else $error("pool overflow without word failure");
`endif

endmodule

`default_nettype wire
